/* hw/rtl/ppm_pkg.sv */
// Shared types and constants for the PPM frame generator.
// No dependencies; imported by the response queue and the top level.
`default_nettype none

package ppm_pkg;

   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_FRAME_LENGTH = 1'b0,
      CSR_SYNC_WIDTH   = 1'b1
   } csr_index_type;

   localparam logic [15:0] RESET_FRAME_LEN = 16'd30500;
   localparam logic [9:0]  RESET_SYNC      = 10'd300;
   localparam logic [11:0] RESET_WIDTH     = 12'd1000;

   typedef struct packed {
      logic       frame_start;
      logic [3:0] slot_number;
      logic       ppm_level;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/ppm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module ppm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/ppm_rsp_fifo.sv */
// Two-entry response queue that decouples the update stage from the output.
// Depends on ppm_pkg for the response item type.
`default_nettype none

module ppm_rsp_fifo
   import ppm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data,
   output logic         room
);

   rsp_type    entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop       = (count_ff != 2'd0) && out_ready;
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      room      = (count_in <= 2'd1);
      out_valid = (count_ff != 2'd0);
      out_data  = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ppm_frame_generator.sv */
// Top level of the PPM frame generator: channel width store, slot sequencer
// and response queue. Depends on ppm_pkg, ppm_ram and ppm_rsp_fifo.
`default_nettype none

// One item is taken every cycle while the result side keeps up; its result is
// registered in the update stage and then in the response queue before it is
// offered: the width RAM is read in the transfer cycle and the sequencer
// updates in the next one, so the registered RAM read sets the depth.
// Channel widths live in a two-bank RAM; a write goes to the bank that the
// running frame does not use, so a frame start swaps banks per channel
// instead of copying. Per-entry valid bits stand in for the reset value, so
// there is no clearing pass after reset.
module ppm_frame_generator
   import ppm_pkg::*;
#(
   parameter int CHANNELS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // channel_index[3:0], channel_value[15:4]
   input  wire logic [0:0]  req_tuser,   // req_type[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // ppm_level[0], slot_number[4:1], zero[7:5]
   output logic [0:0]       rsp_tuser,   // frame_start[0]
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W = CH_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int SLOT_W = $clog2(CHANNELS + 1);
   localparam logic [4:0]        CH_COUNT = 5'(CHANNELS);
   localparam logic [SLOT_W-1:0] SLOT_GAP = SLOT_W'(CHANNELS);
   localparam logic [15:0]       SUM_RESET = 16'(CHANNELS * 1000);

   logic req_accept, req_write, req_idx_ok;
   logic [3:0]  req_idx;
   logic [11:0] req_val;

   logic [15:0] frame_ff;
   logic [9:0]  sync_ff;
   logic [CHANNELS-1:0] pend_bank_ff, pend_bank_in;
   logic [CHANNELS-1:0] act_bank_ff, act_bank_in;
   logic [DEPTH-1:0]    valid_ff, valid_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] gap_ff, gap_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [15:0] count_ff, count_in;
   logic        in_sync_ff, in_sync_in;

   logic              b_valid_ff, b_write_ff, fwd_ff, fwd_in;
   logic [3:0]        b_idx_ff;
   logic [11:0]       b_val_ff, fwd_data_ff;
   logic [ADDR_W-1:0] b_addr_ff;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [11:0]       ram_rdata;

   logic [9:0]  sync_eff;
   logic [15:0] sync16, frame_less_sync, high_len, c1;
   logic [11:0] width_raw, high_ch;
   logic        b_idx_ok, wbank, sync1, frame_start;
   logic [CH_W-1:0] b_ch, a_ch, rd_ch;
   logic        a_bank;
   rsp_type     rsp_item, rsp_out;
   logic        room;

   assign req_accept = req_tvalid && req_tready;
   assign req_write  = (req_kind_type'(req_tuser[0]) == REQ_WRITE);
   assign req_idx    = req_tdata[3:0];
   assign req_val    = req_tdata[15:4];
   assign req_idx_ok = ({1'b0, req_idx} < CH_COUNT);

   always_comb begin
      sync_eff        = (sync_ff == 10'd0) ? 10'd1 : sync_ff;
      sync16          = {6'd0, sync_eff};
      frame_less_sync = frame_ff - sync16;
      b_idx_ok        = ({1'b0, b_idx_ff} < CH_COUNT);
      b_ch            = b_idx_ff[CH_W-1:0];
      width_raw       = valid_ff[b_addr_ff] ? (fwd_ff ? fwd_data_ff : ram_rdata) : RESET_WIDTH;
      high_ch         = (width_raw > {2'd0, sync_eff}) ? (width_raw - {2'd0, sync_eff}) : 12'd0;
      high_len        = (slot_ff >= SLOT_GAP) ? gap_ff : {4'd0, high_ch};

      pend_bank_in = pend_bank_ff;
      act_bank_in  = act_bank_ff;
      valid_in     = valid_ff;
      sum_in       = sum_ff;
      gap_in       = gap_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      in_sync_in   = in_sync_ff;
      ram_we       = 1'b0;
      wbank        = 1'b0;
      ram_waddr    = {wbank, b_ch};
      frame_start  = 1'b0;
      c1           = count_ff;
      sync1        = in_sync_ff;

      if (b_valid_ff) begin
         if (b_write_ff) begin
            if (b_idx_ok) begin
               wbank = (pend_bank_ff[b_ch] == act_bank_ff[b_ch]) ?
                       ~pend_bank_ff[b_ch] : pend_bank_ff[b_ch];
               pend_bank_in[b_ch]       = wbank;
               ram_waddr                = {wbank, b_ch};
               valid_in[{wbank, b_ch}]  = 1'b1;
               ram_we                   = 1'b1;
               sum_in = sum_ff - {4'd0, width_raw} + {4'd0, b_val_ff};
            end
         end else begin
            if ((count_ff == 16'd0) && in_sync_ff) begin
               sync1 = 1'b0;
               c1    = high_len;
            end
            if (c1 == 16'd0) begin
               if (slot_ff >= SLOT_GAP) begin
                  slot_in     = '0;
                  frame_start = 1'b1;
                  act_bank_in = pend_bank_ff;
                  if ((frame_ff > sync16) && (frame_less_sync > sum_ff)) begin
                     gap_in = frame_less_sync - sum_ff;
                  end else begin
                     gap_in = 16'd0;
                  end
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
               sync1 = 1'b1;
               c1    = sync16;
            end
            in_sync_in = sync1;
            count_in   = c1 - 16'd1;
         end
      end

      rsp_item.ppm_level   = ~in_sync_in;
      rsp_item.slot_number = 4'(slot_in);
      rsp_item.frame_start = frame_start;

      a_ch   = req_idx[CH_W-1:0];
      a_bank = req_idx_ok ? pend_bank_in[a_ch] : 1'b0;
      rd_ch  = (slot_in < SLOT_GAP) ? slot_in[CH_W-1:0] : '0;
      if (req_write) begin
         ram_raddr = {a_bank, a_ch};
      end else begin
         ram_raddr = {act_bank_in[rd_ch], rd_ch};
      end
      fwd_in = ram_we && (ram_waddr == ram_raddr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= RESET_FRAME_LEN;
         sync_ff      <= RESET_SYNC;
         pend_bank_ff <= '0;
         act_bank_ff  <= '0;
         valid_ff     <= '0;
         sum_ff       <= SUM_RESET;
         gap_ff       <= 16'd0;
         slot_ff      <= SLOT_GAP;
         count_ff     <= 16'd0;
         in_sync_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_FRAME_LENGTH: frame_ff <= csr_wdata;
               CSR_SYNC_WIDTH:   sync_ff  <= csr_wdata[9:0];
            endcase
         end
         pend_bank_ff <= pend_bank_in;
         act_bank_ff  <= act_bank_in;
         valid_ff     <= valid_in;
         sum_ff       <= sum_in;
         gap_ff       <= gap_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         in_sync_ff   <= in_sync_in;
         b_valid_ff   <= req_accept;
      end
      if (req_accept) begin
         b_write_ff  <= req_write;
         b_idx_ff    <= req_idx;
         b_val_ff    <= req_val;
         b_addr_ff   <= ram_raddr;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= b_val_ff;
      end
   end

   ppm_ram #(
      .WIDTH (12),
      .DEPTH (DEPTH)
   ) u_width_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (b_val_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ppm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (b_valid_ff),
      .push_data (rsp_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out),
      .room      (room)
   );

   assign req_tready = !reset && room;
   assign rsp_tdata  = {3'd0, rsp_out.slot_number, rsp_out.ppm_level};
   assign rsp_tuser  = rsp_out.frame_start;

endmodule

`default_nettype wire

/* hw/rtl/ppm_chk.sv */
// Port-level checker for the PPM frame generator, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module ppm_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // A stalled result transfer keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Every accepted item has its result queued, after the update stage and the queue.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("result missing after accepted item");

   // A frame always begins in the first channel slot.
   a_frame_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[4:1] == 4'd0)
      else $error("frame start outside first slot");

   // A frame always begins with the line in its sync pulse.
   a_frame_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tdata[0])
      else $error("frame start with line high");

endmodule

bind ppm_frame_generator ppm_chk u_ppm_chk (.*);

`default_nettype wire
